@@ rtl/pcs_pkg.sv @@
`timescale 1ns / 1ps
// Package for the PWM channel set-up engine: widths, clock constants,
// sequencer state type and divider status type. No dependencies.
package pcs_pkg;

	localparam int NUM_CHANNELS_DEF = 4;
	localparam int CH_W             = 2;
	localparam int FREQ_W           = 16;
	localparam int DUTY_W           = 14;
	localparam int REG_W            = 16;
	localparam int IMG_W            = 4;

	// Shared divider operand widths: 26 bit clock rate over 16 bit frequency
	localparam int DIVIDEND_W = 26;
	localparam int DIVISOR_W  = 16;

	// Pulse width scaling: the 14 x 16 bit product is divided by 10000 with a
	// reciprocal multiply, floor(x / 10000) = (x * RECIP_10K) >> RECIP_SHIFT,
	// exact for every product up to 10000 * 65535
	localparam int                PROD_W      = 30;
	localparam int                RECIP_SHIFT = 43;
	localparam logic [PROD_W-1:0] RECIP_10K   = PROD_W'(879609303);

	localparam logic [DIVIDEND_W-1:0] FAST_CLK_HZ  = DIVIDEND_W'(40000000);
	localparam logic [DIVIDEND_W-1:0] SLOW_CLK_HZ  = DIVIDEND_W'(40000000 / 64);
	localparam logic [FREQ_W-1:0]     SLOW_LIMIT   = FREQ_W'(700);
	localparam logic [DUTY_W-1:0]     DUTY_FULL    = DUTY_W'(10000);
	localparam logic [REG_W-1:0]      MAX16        = '1;

	// Request codes
	localparam logic REQ_SET_FREQ   = 1'b0;
	localparam logic REQ_SET_ENABLE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PER_DIV,
		ST_MUL,
		ST_SCALE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ rtl/pcs_div.sv @@
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on pcs_pkg for div_stat_t.
module pcs_div #(
	parameter int DIVIDEND_W = pcs_pkg::DIVIDEND_W,
	parameter int DIVISOR_W  = pcs_pkg::DIVISOR_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic [DIVIDEND_W-1:0] quotient,
	output pcs_pkg::div_stat_t    stat
);

	localparam int CNT_W = $clog2(DIVIDEND_W);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W:0]    rem_q;
	logic [DIVIDEND_W-1:0] quo_q;

	logic [DIVISOR_W:0] rem_shift;
	logic [DIVISOR_W:0] diff;
	logic               fits;

	// One trial subtraction per cycle
	assign rem_shift = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
	assign diff      = rem_shift - {1'b0, dvs_q};
	assign fits      = rem_shift >= {1'b0, dvs_q};

	// Control: load on start, count down, pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// Datapath: dividend shifts out as quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff : rem_shift;
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ rtl/pwm_channel_setup_core.sv @@
`timescale 1ns / 1ps
// PWM channel set-up engine: top level with request sequencer, channel
// register file and result register. Depends on pcs_pkg and pcs_div.
//
// Usage: one request channel (in_valid / in_stall) carries req_type, channel,
// frequency_hz, duty_centi_pct and enable_value; one result channel
// (out_valid / out_stall) returns the channel's register images. Every
// request gives exactly one result.
// Sequence: an enable request, an unchanged request, a zero frequency or an
// out-of-range channel goes from the check straight to the result. A
// recompute runs clock / frequency through the shared radix-2 divider,
// then forms duty * period and then the reciprocal scaling by 1/10000.
// Flow: one request at a time; in_stall is high from acceptance until the
// result is written to the output register.
// Stall: the output register holds its transaction while out_stall is high;
// a new request may be accepted meanwhile and waits finished until the
// output register frees.
// Reset: arst_n clears all channel registers (disabled, period and width 0,
// full clock) and the sequencer; no clearing pass is needed.
module pwm_channel_setup_core #(
	parameter int NUM_CHANNELS = pcs_pkg::NUM_CHANNELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       req_type,
	input  logic [pcs_pkg::CH_W-1:0]   channel,
	input  logic [pcs_pkg::FREQ_W-1:0] frequency_hz,
	input  logic [pcs_pkg::DUTY_W-1:0] duty_centi_pct,
	input  logic                       enable_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [pcs_pkg::CH_W-1:0]   channel_out,
	output logic                       updated,
	output logic [pcs_pkg::IMG_W-1:0]  enable_bits,
	output logic [pcs_pkg::IMG_W-1:0]  slow_clock_bits,
	output logic [pcs_pkg::REG_W-1:0]  period_value,
	output logic [pcs_pkg::REG_W-1:0]  pulse_width,
	output logic                       period_saturated
);

	localparam int CH_W   = pcs_pkg::CH_W;
	localparam int FREQ_W = pcs_pkg::FREQ_W;
	localparam int DUTY_W = pcs_pkg::DUTY_W;
	localparam int REG_W  = pcs_pkg::REG_W;
	localparam int IMG_W  = pcs_pkg::IMG_W;
	localparam int DVD_W  = pcs_pkg::DIVIDEND_W;
	localparam int DVS_W  = pcs_pkg::DIVISOR_W;
	localparam int PROD_W = pcs_pkg::PROD_W;

	pcs_pkg::state_t state_q, state_d;

	// Latched request
	logic              req_q;
	logic [CH_W-1:0]   ch_q;
	logic [FREQ_W-1:0] freq_q;
	logic [DUTY_W-1:0] duty_q;
	logic              en_val_q;
	logic              upd_q;
	logic              over_q;

	// Channel registers
	logic [NUM_CHANNELS-1:0] en_q;
	logic [NUM_CHANNELS-1:0] slow_q;
	logic [FREQ_W-1:0]       sfreq_q [NUM_CHANNELS];
	logic [DUTY_W-1:0]       sduty_q [NUM_CHANNELS];
	logic [REG_W-1:0]        per_q   [NUM_CHANNELS];
	logic [REG_W-1:0]        wid_q   [NUM_CHANNELS];

	// Result register
	logic out_valid_q;

	// Control strobes
	logic latch_in, wr_en_req, wr_saved, wr_zero, wr_slow;
	logic div_start, load_prod, wr_period, wr_width, load_out, set_upd;

	// Addressed channel view
	logic              ch_hit;
	logic              cur_en;
	logic [FREQ_W-1:0] cur_freq;
	logic [DUTY_W-1:0] cur_duty;
	logic [REG_W-1:0]  cur_per;
	logic [REG_W-1:0]  cur_wid;
	logic              is_change;
	logic              is_zero;

	logic [DUTY_W-1:0]   duty_clamped;
	logic [PROD_W-1:0]   prod_q;
	logic [2*PROD_W-1:0] scaled;
	logic [REG_W-1:0]    wid_quo;
	logic [DVD_W-1:0]    div_dvd;
	logic [DVS_W-1:0]    div_dvs;
	logic [DVD_W-1:0]    div_quo;
	logic [REG_W-1:0]    per_sat;
	logic                per_over;
	logic [REG_W-1:0]    wid_sat;
	pcs_pkg::div_stat_t  div_stat;

	assign duty_clamped = (duty_centi_pct > pcs_pkg::DUTY_FULL) ?
		pcs_pkg::DUTY_FULL : duty_centi_pct;

	// Read the addressed channel's registers
	always_comb begin
		cur_en   = 1'b0;
		cur_freq = '0;
		cur_duty = '0;
		cur_per  = '0;
		cur_wid  = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (ch_q == CH_W'(i)) begin
				cur_en   = en_q[i];
				cur_freq = sfreq_q[i];
				cur_duty = sduty_q[i];
				cur_per  = per_q[i];
				cur_wid  = wid_q[i];
			end
		end
	end

	assign ch_hit    = int'(ch_q) < NUM_CHANNELS;
	assign is_change = (cur_freq != freq_q) || (cur_duty != duty_q) || !cur_en;
	assign is_zero   = (freq_q == '0);

	// Shared divider: clock / frequency
	assign div_dvd = (freq_q < pcs_pkg::SLOW_LIMIT) ? pcs_pkg::SLOW_CLK_HZ :
		pcs_pkg::FAST_CLK_HZ;
	assign div_dvs = DVS_W'(freq_q);

	pcs_div #(
		.DIVIDEND_W(DVD_W),
		.DIVISOR_W (DVS_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.quotient(div_quo),
		.stat    (div_stat)
	);

	// Saturate the period quotient to 16 bits
	assign per_over = (div_quo[DVD_W-1:REG_W] != '0);
	assign per_sat  = per_over ? pcs_pkg::MAX16 : div_quo[REG_W-1:0];

	// Scale duty * period by 1/10000, then add one and saturate
	assign scaled  = {{PROD_W{1'b0}}, prod_q} * {{PROD_W{1'b0}}, pcs_pkg::RECIP_10K};
	assign wid_quo = scaled[pcs_pkg::RECIP_SHIFT +: REG_W];
	assign wid_sat = (wid_quo == pcs_pkg::MAX16) ? pcs_pkg::MAX16 : (wid_quo + REG_W'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcs_pkg::ST_IDLE: begin
				if (in_valid) state_d = pcs_pkg::ST_CHECK;
			end
			pcs_pkg::ST_CHECK: begin
				if (!ch_hit || req_q == pcs_pkg::REQ_SET_ENABLE || !is_change || is_zero)
					state_d = pcs_pkg::ST_DONE;
				else
					state_d = pcs_pkg::ST_PER_DIV;
			end
			pcs_pkg::ST_PER_DIV: begin
				if (div_stat.done) state_d = pcs_pkg::ST_MUL;
			end
			pcs_pkg::ST_MUL: begin
				state_d = pcs_pkg::ST_SCALE;
			end
			pcs_pkg::ST_SCALE: begin
				state_d = pcs_pkg::ST_DONE;
			end
			pcs_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) state_d = pcs_pkg::ST_IDLE;
			end
			default: state_d = pcs_pkg::ST_IDLE;
		endcase
	end

	// Control strobes per state
	always_comb begin
		latch_in  = 1'b0;
		wr_en_req = 1'b0;
		wr_saved  = 1'b0;
		wr_zero   = 1'b0;
		wr_slow   = 1'b0;
		div_start = 1'b0;
		load_prod = 1'b0;
		wr_period = 1'b0;
		wr_width  = 1'b0;
		load_out  = 1'b0;
		set_upd   = 1'b0;
		unique case (state_q)
			pcs_pkg::ST_IDLE: begin
				latch_in = in_valid;
			end
			pcs_pkg::ST_CHECK: begin
				if (ch_hit) begin
					if (req_q == pcs_pkg::REQ_SET_ENABLE) begin
						wr_en_req = 1'b1;
						set_upd   = 1'b1;
					end else if (is_change) begin
						wr_saved = 1'b1;
						set_upd  = 1'b1;
						if (is_zero) begin
							wr_zero = 1'b1;
						end else begin
							wr_slow   = 1'b1;
							div_start = 1'b1;
						end
					end
				end
			end
			pcs_pkg::ST_PER_DIV: begin
				wr_period = div_stat.done;
			end
			pcs_pkg::ST_MUL: begin
				load_prod = 1'b1;
			end
			pcs_pkg::ST_SCALE: begin
				wr_width = 1'b1;
			end
			pcs_pkg::ST_DONE: begin
				load_out = !out_valid_q || !out_stall;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pcs_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// Hold the accepted transaction and its flags
	always_ff @(posedge clk) begin
		if (latch_in) begin
			req_q    <= req_type;
			ch_q     <= channel;
			freq_q   <= frequency_hz;
			duty_q   <= duty_clamped;
			en_val_q <= enable_value;
			upd_q    <= 1'b0;
			over_q   <= 1'b0;
		end else begin
			if (set_upd)   upd_q  <= 1'b1;
			if (wr_period) over_q <= per_over;
		end
	end

	// Form duty * period from the freshly written period
	always_ff @(posedge clk) begin
		if (load_prod) prod_q <= PROD_W'(duty_q) * PROD_W'(cur_per);
	end

	// Update the addressed channel's registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= '0;
			slow_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				sfreq_q[i] <= '0;
				sduty_q[i] <= '0;
				per_q[i]   <= '0;
				wid_q[i]   <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (ch_q == CH_W'(i)) begin
					if (wr_en_req) en_q[i] <= en_val_q;
					if (wr_saved) begin
						sfreq_q[i] <= freq_q;
						sduty_q[i] <= duty_q;
					end
					if (wr_zero) begin
						en_q[i]  <= 1'b0;
						per_q[i] <= '0;
						wid_q[i] <= REG_W'(1);
					end
					if (wr_slow) slow_q[i] <= (freq_q < pcs_pkg::SLOW_LIMIT);
					if (wr_period) begin
						per_q[i] <= per_sat;
						en_q[i]  <= 1'b1;
					end
					if (wr_width) wid_q[i] <= wid_sat;
				end
			end
		end
	end

	// Result register: load when free, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)         out_valid_q <= 1'b0;
		else if (load_out)   out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			channel_out      <= ch_q;
			updated          <= upd_q;
			enable_bits      <= IMG_W'(en_q);
			slow_clock_bits  <= IMG_W'(slow_q);
			period_value     <= cur_per;
			pulse_width      <= cur_wid;
			period_saturated <= over_q;
		end
	end

	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != pcs_pkg::ST_IDLE);

	// Divider is never restarted while it runs
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// Divider completes only while the sequencer waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == pcs_pkg::ST_PER_DIV))
		else $error("divider done outside the divide state");

	// A saturated period shows as all ones
	a_sat_period: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && period_saturated) |-> (period_value == pcs_pkg::MAX16))
		else $error("saturation flag without saturated period");

	// A freshly loaded result is presented in the next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("result loaded but not presented");

endmodule

@@ bench/pwm_channel_setup_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for pwm_channel_setup_core: directed and random set-up
// requests, an in-bench model of the channel registers, randomized idling on
// both channels. Depends on pcs_pkg and the RTL of the core.
module pwm_channel_setup_core_test;

	localparam int NUM_CH        = pcs_pkg::NUM_CHANNELS_DEF;
	localparam int CH_W          = pcs_pkg::CH_W;
	localparam int FREQ_W        = pcs_pkg::FREQ_W;
	localparam int DUTY_W        = pcs_pkg::DUTY_W;
	localparam int REG_W         = pcs_pkg::REG_W;
	localparam int IMG_W         = pcs_pkg::IMG_W;
	localparam int RANDOM_ITEMS  = 1230;
	localparam int SETTLE_CYCLES = 100;
	localparam int MAX_PRINTED   = 50;

	typedef struct packed {
		logic              kind;
		logic [CH_W-1:0]   ch;
		logic [FREQ_W-1:0] freq;
		logic [DUTY_W-1:0] duty;
		logic              en;
	} setup_req_t;

	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic             upd;
		logic [IMG_W-1:0] en_img;
		logic [IMG_W-1:0] slow_img;
		logic [REG_W-1:0] period;
		logic [REG_W-1:0] width;
		logic             sat;
	} setup_result_t;

	typedef enum int {SINK_FREE, SINK_RANDOM, SINK_HEAVY} sink_mode_t;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              in_valid       = 1'b0;
	logic              in_stall;
	logic              req_type       = pcs_pkg::REQ_SET_FREQ;
	logic [CH_W-1:0]   channel        = '0;
	logic [FREQ_W-1:0] frequency_hz   = '0;
	logic [DUTY_W-1:0] duty_centi_pct = '0;
	logic              enable_value   = 1'b0;
	logic              out_valid;
	logic              out_stall      = 1'b0;
	logic [CH_W-1:0]   channel_out;
	logic              updated;
	logic [IMG_W-1:0]  enable_bits;
	logic [IMG_W-1:0]  slow_clock_bits;
	logic [REG_W-1:0]  period_value;
	logic [REG_W-1:0]  pulse_width;
	logic              period_saturated;

	// Shadow copy of the channel register file
	logic              ch_on[NUM_CH]      = '{default: 1'b0};
	logic [FREQ_W-1:0] saved_freq[NUM_CH] = '{default: '0};
	logic [DUTY_W-1:0] saved_duty[NUM_CH] = '{default: '0};
	logic [REG_W-1:0]  period_img[NUM_CH] = '{default: '0};
	logic [REG_W-1:0]  width_img[NUM_CH]  = '{default: '0};
	logic              slow_sel[NUM_CH]   = '{default: 1'b0};

	setup_req_t    request_queue[$];
	setup_result_t expected_images[$];
	setup_req_t    driven_req;

	int         burst_left      = 0;
	int         gap_left        = 0;
	sink_mode_t sink_mode       = SINK_FREE;
	int         sink_phase      = 0;
	int         requests_sent   = 0;
	int         results_checked = 0;
	int         unchanged_seen  = 0;
	int         saturated_seen  = 0;
	int         mismatches      = 0;

	pwm_channel_setup_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.req_type         (req_type),
		.channel          (channel),
		.frequency_hz     (frequency_hz),
		.duty_centi_pct   (duty_centi_pct),
		.enable_value     (enable_value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.channel_out      (channel_out),
		.updated          (updated),
		.enable_bits      (enable_bits),
		.slow_clock_bits  (slow_clock_bits),
		.period_value     (period_value),
		.pulse_width      (pulse_width),
		.period_saturated (period_saturated)
	);

	always #4 clk = ~clk;

	// Apply one request to the shadow registers and build its result image
	function automatic setup_result_t apply_setup_request(setup_req_t rq);
		setup_result_t r;
		int unsigned   duty;
		int unsigned   freq;
		int unsigned   clk_hz;
		int unsigned   quotient;
		int unsigned   scaled;
		r      = '0;
		r.ch   = rq.ch;
		duty   = 32'(rq.duty);
		freq   = 32'(rq.freq);
		if (duty > 32'(pcs_pkg::DUTY_FULL))
			duty = 32'(pcs_pkg::DUTY_FULL);
		if (int'(rq.ch) < NUM_CH) begin
			if (rq.kind == pcs_pkg::REQ_SET_ENABLE) begin
				ch_on[rq.ch] = rq.en;
				r.upd = 1'b1;
			end else if (32'(saved_freq[rq.ch]) != freq ||
					32'(saved_duty[rq.ch]) != duty || !ch_on[rq.ch]) begin
				saved_freq[rq.ch] = FREQ_W'(freq);
				saved_duty[rq.ch] = DUTY_W'(duty);
				if (freq == 0) begin
					// zero frequency: disable, keep the clock choice
					ch_on[rq.ch] = 1'b0;
					period_img[rq.ch] = '0;
				end else begin
					if (freq < 32'(pcs_pkg::SLOW_LIMIT)) begin
						slow_sel[rq.ch] = 1'b1;
						clk_hz = 32'(pcs_pkg::SLOW_CLK_HZ);
					end else begin
						slow_sel[rq.ch] = 1'b0;
						clk_hz = 32'(pcs_pkg::FAST_CLK_HZ);
					end
					quotient = clk_hz / freq;
					if (quotient > 32'(pcs_pkg::MAX16)) begin
						r.sat = 1'b1;
						period_img[rq.ch] = pcs_pkg::MAX16;
					end else begin
						period_img[rq.ch] = REG_W'(quotient);
					end
					ch_on[rq.ch] = 1'b1;
				end
				scaled = duty * 32'(period_img[rq.ch]) / 32'(pcs_pkg::DUTY_FULL) + 32'd1;
				width_img[rq.ch] = (scaled > 32'(pcs_pkg::MAX16)) ?
					pcs_pkg::MAX16 : REG_W'(scaled);
				r.upd = 1'b1;
			end
			r.period = period_img[rq.ch];
			r.width  = width_img[rq.ch];
		end
		for (int i = 0; i < NUM_CH; i++) begin
			r.en_img[i]   = ch_on[i];
			r.slow_img[i] = slow_sel[i];
		end
		return r;
	endfunction

	task automatic queue_request(input logic kind, input int ch, input int freq,
			input int duty, input logic en);
		setup_req_t rq;
		rq.kind = kind;
		rq.ch   = CH_W'(ch);
		rq.freq = FREQ_W'(freq);
		rq.duty = DUTY_W'(duty);
		rq.en   = en;
		request_queue.push_back(rq);
	endtask

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		if (mismatches < MAX_PRINTED)
			$display("mismatch at result %0d: %s expected %0d got %0d",
				results_checked, what, want, got);
		mismatches++;
	endtask

	// Driver: predict on each accepted transaction, then launch the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_images.push_back(apply_setup_request(driven_req));
				requests_sent++;
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (request_queue.size() > 0) begin
					driven_req = request_queue.pop_front();
					req_type       <= driven_req.kind;
					channel        <= driven_req.ch;
					frequency_hz   <= driven_req.freq;
					duty_centi_pct <= driven_req.duty;
					enable_value   <= driven_req.en;
					in_valid       <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 3) == 0) ?
							$urandom_range(4, 40) : $urandom_range(0, 3);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result, then pick the next stall value
	always @(posedge clk) begin : monitor
		setup_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_images.size() == 0) begin
					report_mismatch("unexpected result on channel", 0, 32'(channel_out));
				end else begin
					want = expected_images.pop_front();
					if (channel_out !== want.ch)
						report_mismatch("channel_out", 32'(want.ch), 32'(channel_out));
					if (updated !== want.upd)
						report_mismatch("updated", 32'(want.upd), 32'(updated));
					if (enable_bits !== want.en_img)
						report_mismatch("enable_bits", 32'(want.en_img), 32'(enable_bits));
					if (slow_clock_bits !== want.slow_img)
						report_mismatch("slow_clock_bits", 32'(want.slow_img),
							32'(slow_clock_bits));
					if (period_value !== want.period)
						report_mismatch("period_value", 32'(want.period), 32'(period_value));
					if (pulse_width !== want.width)
						report_mismatch("pulse_width", 32'(want.width), 32'(pulse_width));
					if (period_saturated !== want.sat)
						report_mismatch("period_saturated", 32'(want.sat),
							32'(period_saturated));
					if (!want.upd)
						unchanged_seen++;
					if (want.sat)
						saturated_seen++;
				end
				results_checked++;
			end
			if (sink_phase == 0) begin
				sink_mode  = sink_mode_t'($urandom_range(0, 2));
				sink_phase = $urandom_range(100, 600);
			end else begin
				sink_phase--;
			end
			case (sink_mode)
				SINK_FREE:   out_stall <= 1'b0;
				SINK_RANDOM: out_stall <= 1'($urandom_range(0, 1));
				default:     out_stall <= ($urandom_range(0, 15) != 0);
			endcase
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int   roll;
		int   ch;
		int   freq;
		int   duty;
		logic kind;
		int   last_freq[NUM_CH];
		int   last_duty[NUM_CH];

		// directed: clock select edges, saturation, clamping, repeats, disable
		queue_request(pcs_pkg::REQ_SET_FREQ, 0, 1000, 5000, 1'b0);
		queue_request(pcs_pkg::REQ_SET_FREQ, 0, 1000, 5000, 1'b1);
		queue_request(pcs_pkg::REQ_SET_FREQ, 0, 1000, 16383, 1'b0);
		queue_request(pcs_pkg::REQ_SET_FREQ, 0, 1000, 12345, 1'b1);
		queue_request(pcs_pkg::REQ_SET_FREQ, 1, 1, 10000, 1'b0);
		queue_request(pcs_pkg::REQ_SET_FREQ, 1, 9, 0, 1'b1);
		queue_request(pcs_pkg::REQ_SET_FREQ, 1, 10, 3333, 1'b0);
		queue_request(pcs_pkg::REQ_SET_FREQ, 2, 699, 7500, 1'b0);
		queue_request(pcs_pkg::REQ_SET_FREQ, 2, 700, 7500, 1'b1);
		queue_request(pcs_pkg::REQ_SET_FREQ, 3, 65535, 1, 1'b0);
		queue_request(pcs_pkg::REQ_SET_FREQ, 3, 0, 5000, 1'b0);
		queue_request(pcs_pkg::REQ_SET_FREQ, 3, 0, 5000, 1'b1);
		queue_request(pcs_pkg::REQ_SET_ENABLE, 3, 0, 0, 1'b1);
		queue_request(pcs_pkg::REQ_SET_FREQ, 3, 0, 5000, 1'b0);
		queue_request(pcs_pkg::REQ_SET_ENABLE, 0, 65535, 16383, 1'b0);
		queue_request(pcs_pkg::REQ_SET_FREQ, 0, 1000, 10000, 1'b0);
		queue_request(pcs_pkg::REQ_SET_FREQ, 2, 500, 0, 1'b1);
		queue_request(pcs_pkg::REQ_SET_FREQ, 2, 0, 0, 1'b0);
		queue_request(pcs_pkg::REQ_SET_ENABLE, 1, 65535, 16383, 1'b0);
		queue_request(pcs_pkg::REQ_SET_FREQ, 2, 0, 0, 1'b1);
		queue_request(pcs_pkg::REQ_SET_ENABLE, 2, 43690, 10922, 1'b1);
		queue_request(pcs_pkg::REQ_SET_FREQ, 1, 21845, 5461, 1'b1);

		foreach (last_freq[i]) begin
			last_freq[i] = 0;
			last_duty[i] = 0;
		end

		// random: mostly fresh set-ups, many exact repeats, some enable writes
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			ch   = $urandom_range(0, NUM_CH - 1);
			roll = $urandom_range(0, 99);
			kind = pcs_pkg::REQ_SET_FREQ;
			if (roll < 20) begin
				kind = pcs_pkg::REQ_SET_ENABLE;
				freq = $urandom_range(0, 65535);
				duty = $urandom_range(0, 16383);
			end else if (roll < 45) begin
				freq = last_freq[ch];
				duty = last_duty[ch];
				if (duty >= int'(pcs_pkg::DUTY_FULL) && $urandom_range(0, 1))
					duty = $urandom_range(10000, 16383);
			end else begin
				case ($urandom_range(0, 7))
					0:       freq = 0;
					1:       freq = $urandom_range(1, 12);
					2:       freq = $urandom_range(13, 699);
					3:       freq = $urandom_range(695, 705);
					4, 5:    freq = $urandom_range(700, 65535);
					6:       freq = $urandom_range(0, 65535);
					default: freq = 65535 - $urandom_range(0, 3);
				endcase
				case ($urandom_range(0, 5))
					0:       duty = 0;
					1:       duty = 10000;
					2:       duty = $urandom_range(10001, 16383);
					3:       duty = $urandom_range(0, 16383);
					default: duty = $urandom_range(0, 10000);
				endcase
			end
			if (kind == pcs_pkg::REQ_SET_FREQ) begin
				last_freq[ch] = freq;
				last_duty[ch] = duty;
			end
			queue_request(kind, ch, freq, duty, 1'($urandom_range(0, 1)));
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// drain: every request accepted and every result seen
		do
			@(negedge clk);
		while (request_queue.size() != 0 || in_valid || expected_images.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Ran %0d set-up requests, %0d results checked, %0d mismatches.",
			requests_sent, results_checked, mismatches);
		$display("Unchanged requests seen: %0d, saturated periods seen: %0d.",
			unchanged_seen, saturated_seen);
		if (mismatches == 0 && expected_images.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#12_000_000;
		$display("timeout: %0d of %0d results seen", results_checked, requests_sent);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
